>>> hw/rtl/ucb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared types and codes for the UART to SPI command bridge.
// ----------------------------------------------------------------------------
package ucb_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned CNT_W     = 2;

    // result queue: must hold at least MAX_RES entries, power of two
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_UART_RX  = 2'd1;
    localparam logic [OP_W-1:0] OP_SPI_DONE = 2'd2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_UART = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPI  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CS   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEND  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPLY = 1'd1;

    localparam logic [BYTE_W-1:0] MAX_SEND_RST  = 8'd33;
    localparam logic [BYTE_W-1:0] MAX_REPLY_RST = 8'd32;

    // protocol characters
    localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h24;

    // phases
    localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NSEND  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_NREPLY = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SBYTE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SXFER  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_RXFER  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_ERR    = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

    // results of one request, handed to the result queue
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        t_result [MAX_RES-1:0]     res;
    } t_push;

    function automatic t_result mk_res(input logic [ACT_W-1:0] act,
                                       input logic [BYTE_W-1:0] val,
                                       input logic lst);
        t_result r;
        r.action = act;
        r.value  = val;
        r.last   = lst;
        return r;
    endfunction

endpackage

>>> hw/rtl/ucb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_ctrl
// Input register, config registers, command state and per-request decode.
// ----------------------------------------------------------------------------
module ucb_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ucb_pkg::OP_W-1:0]          i_operation,
    input  logic [ucb_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_cfg_we,
    input  logic [ucb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ucb_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic [ucb_pkg::RQ_CW-1:0]         i_free,
    output logic                              o_push_en,
    output ucb_pkg::t_push                    o_push
);

    logic                          r_in_vld;
    logic [ucb_pkg::OP_W-1:0]      r_op;
    logic [ucb_pkg::BYTE_W-1:0]    r_byte;
    logic [ucb_pkg::BYTE_W-1:0]    r_max_send;
    logic [ucb_pkg::BYTE_W-1:0]    r_max_reply;
    logic [ucb_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [ucb_pkg::BYTE_W-1:0]    r_send_left, n_send_left;
    logic [ucb_pkg::BYTE_W-1:0]    r_reply_left, n_reply_left;
    ucb_pkg::t_push                push;
    logic [ucb_pkg::BYTE_W-1:0]    send_dec;
    logic [ucb_pkg::BYTE_W-1:0]    reply_dec;
    logic                          advance;
    logic                          in_acc;

    assign send_dec  = r_send_left - 8'd1;
    assign reply_dec = r_reply_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_send_left  = r_send_left;
        n_reply_left = r_reply_left;
        push.cnt     = '0;
        push.res     = '0;
        case (r_phase)
            ucb_pkg::PH_START: begin
                if (r_op == ucb_pkg::OP_START) begin
                    push.cnt    = 2'd1;
                    push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_PROMPT, 1'b1);
                    n_phase     = ucb_pkg::PH_CMD;
                end
            end
            ucb_pkg::PH_CMD: begin
                if (r_op == ucb_pkg::OP_UART_RX) begin
                    if (r_byte == ucb_pkg::CH_EQUAL) begin
                        n_phase = ucb_pkg::PH_NSEND;
                    end else begin
                        push.cnt    = 2'd1;
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_BANG, 1'b1);
                        n_phase     = ucb_pkg::PH_ERR;
                    end
                end
            end
            ucb_pkg::PH_NSEND: begin
                if (r_op == ucb_pkg::OP_UART_RX) begin
                    if (r_byte == '0 || r_byte > r_max_send) begin
                        push.cnt    = 2'd1;
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_BANG, 1'b1);
                        n_phase     = ucb_pkg::PH_ERR;
                    end else begin
                        n_send_left = r_byte;
                        n_phase     = ucb_pkg::PH_NREPLY;
                    end
                end
            end
            ucb_pkg::PH_NREPLY: begin
                if (r_op == ucb_pkg::OP_UART_RX) begin
                    push.cnt = 2'd1;
                    if (r_byte > r_max_reply) begin
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_BANG, 1'b1);
                        n_phase     = ucb_pkg::PH_ERR;
                    end else begin
                        n_reply_left = r_byte;
                        push.res[0]  = ucb_pkg::mk_res(ucb_pkg::ACT_CS, 8'd0, 1'b1);
                        n_phase      = ucb_pkg::PH_SBYTE;
                    end
                end
            end
            ucb_pkg::PH_SBYTE: begin
                if (r_op == ucb_pkg::OP_UART_RX) begin
                    push.cnt    = 2'd1;
                    push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_SPI, r_byte, 1'b1);
                    n_phase     = ucb_pkg::PH_SXFER;
                end
            end
            ucb_pkg::PH_SXFER: begin
                if (r_op == ucb_pkg::OP_SPI_DONE) begin
                    n_send_left = send_dec;
                    if (send_dec != '0) begin
                        n_phase = ucb_pkg::PH_SBYTE;
                    end else if (r_reply_left != '0) begin
                        push.cnt    = 2'd1;
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_SPI, 8'd0, 1'b1);
                        n_phase     = ucb_pkg::PH_RXFER;
                    end else begin
                        // no reply: release CS and prompt right away
                        push.cnt    = 2'd2;
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_CS, 8'd1, 1'b0);
                        push.res[1] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_PROMPT, 1'b1);
                        n_phase     = ucb_pkg::PH_CMD;
                    end
                end
            end
            ucb_pkg::PH_RXFER: begin
                if (r_op == ucb_pkg::OP_SPI_DONE) begin
                    n_reply_left = reply_dec;
                    push.res[0]  = ucb_pkg::mk_res(ucb_pkg::ACT_UART, r_byte, 1'b0);
                    if (reply_dec != '0) begin
                        push.cnt    = 2'd2;
                        push.res[1] = ucb_pkg::mk_res(ucb_pkg::ACT_SPI, 8'd0, 1'b1);
                    end else begin
                        push.cnt    = 2'd3;
                        push.res[1] = ucb_pkg::mk_res(ucb_pkg::ACT_CS, 8'd1, 1'b0);
                        push.res[2] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_PROMPT, 1'b1);
                        n_phase     = ucb_pkg::PH_CMD;
                    end
                end
            end
            default: begin
                // error mode: answer each byte with a bang until newline, then prompt
                if (r_op == ucb_pkg::OP_UART_RX) begin
                    push.cnt = 2'd1;
                    if (r_byte == ucb_pkg::CH_NL) begin
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_PROMPT, 1'b1);
                        n_phase     = ucb_pkg::PH_CMD;
                    end else begin
                        push.res[0] = ucb_pkg::mk_res(ucb_pkg::ACT_UART, ucb_pkg::CH_BANG, 1'b1);
                    end
                end
            end
        endcase
    end

    assign advance    = r_in_vld && ({{(ucb_pkg::RQ_CW-ucb_pkg::CNT_W){1'b0}}, push.cnt} <= i_free);
    assign o_in_stall = !i_rst_n || (r_in_vld && !advance);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_push_en  = advance;
    assign o_push     = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_phase      <= ucb_pkg::PH_START;
            r_send_left  <= '0;
            r_reply_left <= '0;
            r_max_send   <= ucb_pkg::MAX_SEND_RST;
            r_max_reply  <= ucb_pkg::MAX_REPLY_RST;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_send_left  <= n_send_left;
                r_reply_left <= n_reply_left;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ucb_pkg::CFG_MAX_SEND:  r_max_send  <= i_cfg_data;
                    ucb_pkg::CFG_MAX_REPLY: r_max_reply <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_operation;
            r_byte <= i_data_byte;
        end
    end

endmodule

>>> hw/rtl/ucb_rfifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_rfifo
// Result queue: takes up to three results per cycle, drains one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ucb_rfifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push_en,
    input  ucb_pkg::t_push                i_push,
    output logic [ucb_pkg::RQ_CW-1:0]     o_free,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ucb_pkg::t_result              o_res
);

    ucb_pkg::t_result              r_q [ucb_pkg::RQ_DEPTH];
    logic [ucb_pkg::RQ_AW-1:0]     r_wp;
    logic [ucb_pkg::RQ_AW-1:0]     r_rp;
    logic [ucb_pkg::RQ_CW-1:0]     r_cnt;
    logic [ucb_pkg::RQ_CW-1:0]     push_n;
    logic                          pop;

    assign push_n      = i_push_en ? {{(ucb_pkg::RQ_CW-ucb_pkg::CNT_W){1'b0}}, i_push.cnt} : '0;
    assign o_free      = ucb_pkg::RQ_CW'(ucb_pkg::RQ_DEPTH) - r_cnt;
    // no result is offered while reset is held
    assign o_out_valid = i_rst_n && (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_res       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push_n[ucb_pkg::RQ_AW-1:0];
            r_rp  <= r_rp + ucb_pkg::RQ_AW'(pop);
            r_cnt <= r_cnt + push_n - ucb_pkg::RQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ucb_pkg::MAX_RES; k++) begin
            if (i_push_en && (k < int'(i_push.cnt))) begin
                r_q[r_wp + ucb_pkg::RQ_AW'(k)] <= i_push.res[k];
            end
        end
    end

endmodule

>>> hw/rtl/uart_to_spi_command_bridge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_to_spi_command_bridge
// Path: an accepted request is held in the input register, its results go
//   into the result queue, and the head of that queue drives the output.
// Throughput: one request per cycle while each yields at most one result and
//   the output is not stalled; a multi-result request drains one at a time.
// Reset (synchronous, active low): awaiting start, counts zero, limits 33/32.
// ----------------------------------------------------------------------------
module uart_to_spi_command_bridge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ucb_pkg::OP_W-1:0]          i_operation,
    input  logic [ucb_pkg::BYTE_W-1:0]        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ucb_pkg::ACT_W-1:0]         o_action,
    output logic [ucb_pkg::BYTE_W-1:0]        o_value,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [ucb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ucb_pkg::BYTE_W-1:0]        i_cfg_data
);

    logic [ucb_pkg::RQ_CW-1:0] free;
    logic                      push_en;
    ucb_pkg::t_push            push;
    ucb_pkg::t_result          res;

    ucb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_free      (free),
        .o_push_en   (push_en),
        .o_push      (push)
    );

    ucb_rfifo u_rfifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (push_en),
        .i_push      (push),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_action = res.action;
    assign o_value  = res.value;
    assign o_last   = res.last;

endmodule

>>> hw/rtl/ucb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_checker
// Port-level checks for the command bridge, bound to the top level.
// ----------------------------------------------------------------------------
module ucb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [ucb_pkg::ACT_W-1:0]         o_action,
    input  logic [ucb_pkg::BYTE_W-1:0]        o_value,
    input  logic                              o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action)
            && $stable(o_value) && $stable(o_last))
        else $error("result changed under stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_act_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_action == ucb_pkg::ACT_UART || o_action == ucb_pkg::ACT_SPI
            || o_action == ucb_pkg::ACT_CS))
        else $error("illegal action code");

    a_cs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ucb_pkg::ACT_CS |-> (o_value == 8'd0 || o_value == 8'd1))
        else $error("chip select level not 0/1");

    // CS release is always followed by the prompt of the same request
    a_cs_rel_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ucb_pkg::ACT_CS && o_value == 8'd1 |-> !o_last)
        else $error("CS release marked last");

endmodule

bind uart_to_spi_command_bridge ucb_checker u_ucb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_action    (o_action),
    .o_value     (o_value),
    .o_last      (o_last)
);

>>> verif/ucb_bridge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_bridge_checker
// Watches the request, result and register ports of the UART to SPI command
// bridge, predicts the actions each accepted request must produce and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module ucb_bridge_checker import ucb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [BYTE_W-1:0]    i_value,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [PHASE_W-1:0] cmd_phase;
    logic [BYTE_W-1:0]  sends_left;
    logic [BYTE_W-1:0]  replies_left;
    logic [BYTE_W-1:0]  lim_send;
    logic [BYTE_W-1:0]  lim_reply;

    t_result step_actions[$];
    t_result expected_actions[$];
    int      mismatch_count = 0;
    int      pending_n = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_n;

    function automatic void emit(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] val);
        t_result r;
        r.action = act;
        r.value  = val;
        r.last   = 1'b0;
        step_actions.push_back(r);
    endfunction

    function automatic void reject_command();
        emit(ACT_UART, CH_BANG);
        cmd_phase = PH_ERR;
    endfunction

    // chip select up, then a fresh prompt
    function automatic void end_command();
        emit(ACT_CS, 8'd1);
        emit(ACT_UART, CH_PROMPT);
        cmd_phase = PH_CMD;
    endfunction

    task automatic predict_bridge_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        step_actions.delete();
        case (cmd_phase)
            PH_START: begin
                if (op == OP_START) begin
                    emit(ACT_UART, CH_PROMPT);
                    cmd_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (op == OP_UART_RX) begin
                    if (b == CH_EQUAL) cmd_phase = PH_NSEND;
                    else reject_command();
                end
            end
            PH_NSEND: begin
                if (op == OP_UART_RX) begin
                    if (b == '0 || b > lim_send) begin
                        reject_command();
                    end else begin
                        sends_left = b;
                        cmd_phase  = PH_NREPLY;
                    end
                end
            end
            PH_NREPLY: begin
                if (op == OP_UART_RX) begin
                    if (b > lim_reply) begin
                        reject_command();
                    end else begin
                        replies_left = b;
                        emit(ACT_CS, 8'd0);
                        cmd_phase = PH_SBYTE;
                    end
                end
            end
            PH_SBYTE: begin
                if (op == OP_UART_RX) begin
                    emit(ACT_SPI, b);
                    cmd_phase = PH_SXFER;
                end
            end
            PH_SXFER: begin
                // read-back of a send byte is dropped
                if (op == OP_SPI_DONE) begin
                    sends_left = sends_left - 8'd1;
                    if (sends_left != '0) begin
                        cmd_phase = PH_SBYTE;
                    end else if (replies_left != '0) begin
                        emit(ACT_SPI, 8'd0);
                        cmd_phase = PH_RXFER;
                    end else begin
                        end_command();
                    end
                end
            end
            PH_RXFER: begin
                if (op == OP_SPI_DONE) begin
                    emit(ACT_UART, b);
                    replies_left = replies_left - 8'd1;
                    if (replies_left != '0) emit(ACT_SPI, 8'd0);
                    else end_command();
                end
            end
            default: begin
                if (op == OP_UART_RX) begin
                    if (b == CH_NL) begin
                        emit(ACT_UART, CH_PROMPT);
                        cmd_phase = PH_CMD;
                    end else begin
                        emit(ACT_UART, CH_BANG);
                    end
                end
            end
        endcase
        if (step_actions.size() != 0) step_actions[step_actions.size() - 1].last = 1'b1;
        foreach (step_actions[k]) expected_actions.push_back(step_actions[k]);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            cmd_phase    = PH_START;
            sends_left   = '0;
            replies_left = '0;
            lim_send     = MAX_SEND_RST;
            lim_reply    = MAX_REPLY_RST;
            expected_actions.delete();
        end else begin
            // a result never leaves in the cycle its request enters
            if (i_out_valid && !i_out_stall) begin
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual action %0d value 0x%02h last %0b",
                             $time, i_action, i_value, i_last);
                    mismatch_count++;
                end else begin
                    want = expected_actions.pop_front();
                    bad  = 1'b0;
                    if (i_action !== want.action) begin
                        $display("%0t: action expected %0d actual %0d",
                                 $time, want.action, i_action);
                        bad = 1'b1;
                    end
                    if (i_value !== want.value) begin
                        $display("%0t: value expected 0x%02h actual 0x%02h",
                                 $time, want.value, i_value);
                        bad = 1'b1;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, i_last);
                        bad = 1'b1;
                    end
                    if (bad) mismatch_count++;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_SEND) lim_send = i_cfg_data;
                else if (i_cfg_index == CFG_MAX_REPLY) lim_reply = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_bridge_step(i_operation, i_data_byte);
        end
        pending_n = expected_actions.size();
    end

endmodule

>>> verif/tb_uart_to_spi_command_bridge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_to_spi_command_bridge
// Drives host commands, SPI completions and stray events into the bridge
// under changing count limits and idle patterns; the checker beside the
// block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_uart_to_spi_command_bridge;
    import ucb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic [OP_W-1:0]      req_op = OP_START;
    logic [BYTE_W-1:0]    req_byte = '0;
    logic                 res_stall = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_SEND;
    logic [BYTE_W-1:0]    cfg_data = '0;

    logic                 req_stall;
    logic                 res_valid;
    logic [ACT_W-1:0]     res_action;
    logic [BYTE_W-1:0]    res_value;
    logic                 res_last;
    int                   fail_count;
    int                   pending;

    int tx_idle_pct = 28;
    int rx_stall_pct = 76;
    int noise_pct = 10;
    int lim_send = int'(MAX_SEND_RST);
    int lim_reply = int'(MAX_REPLY_RST);
    int phase_items = 0;
    int quiet_cycles = 0;
    bit hold_off_req = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    uart_to_spi_command_bridge dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_operation (req_op),
        .i_data_byte (req_byte),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_action    (res_action),
        .o_value     (res_value),
        .o_last      (res_last),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ucb_bridge_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_operation  (req_op),
        .i_data_byte  (req_byte),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_action     (res_action),
        .i_value      (res_value),
        .i_last       (res_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && ((req_valid && !req_stall) || (res_valid && !res_stall))) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid is left high after acceptance; the next call decides idle or not
    task automatic send_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                            input bit counted);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_byte  <= b;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (counted) phase_items++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input int s, input int r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_SEND;
        cfg_data  <= 8'(s);
        @(posedge clk);
        cfg_index <= CFG_MAX_REPLY;
        cfg_data  <= 8'(r);
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_send  = s;
        lim_reply = r;
    endtask

    // stray event that the current phase must ignore
    task automatic maybe_noise(input bit want_uart);
        logic [OP_W-1:0] op;
        if ($urandom_range(99) >= noise_pct) return;
        case ($urandom_range(2))
            0: op = OP_START;
            1: op = want_uart ? OP_SPI_DONE : OP_UART_RX;
            default: op = OP_UNUSED;
        endcase
        send_req(op, 8'($urandom), 1'b0);
    endtask

    function automatic int pick_count(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 8) return (hi > 40) ? lo + 12 : hi;
        if (r < 16) return lo;
        return $urandom_range(lo, (hi < lo + 5) ? hi : lo + 5);
    endfunction

    task automatic send_cmd(input int ns, input int nr);
        int k;
        send_req(OP_UART_RX, CH_EQUAL, 1'b1);
        maybe_noise(1'b1);
        send_req(OP_UART_RX, 8'(ns), 1'b1);
        maybe_noise(1'b1);
        send_req(OP_UART_RX, 8'(nr), 1'b1);
        for (k = 0; k < ns; k++) begin
            maybe_noise(1'b1);
            send_req(OP_UART_RX, 8'($urandom), 1'b1);
            maybe_noise(1'b0);
            send_req(OP_SPI_DONE, 8'($urandom), 1'b1);
        end
        for (k = 0; k < nr; k++) begin
            maybe_noise(1'b0);
            send_req(OP_SPI_DONE, 8'($urandom), 1'b1);
        end
    endtask

    // bad command byte or count out of range, some error-mode bytes, newline
    task automatic send_broken();
        int kind;
        int k;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(3);
        if (kind == 0) begin
            do b = 8'($urandom); while (b == CH_EQUAL);
            send_req(OP_UART_RX, b, 1'b1);
        end else begin
            send_req(OP_UART_RX, CH_EQUAL, 1'b1);
            if (kind == 2 && lim_send < 255) begin
                send_req(OP_UART_RX, 8'($urandom_range(lim_send + 1, 255)), 1'b1);
            end else if (kind == 3 && lim_reply < 255) begin
                send_req(OP_UART_RX, 8'(pick_count(1, lim_send)), 1'b1);
                send_req(OP_UART_RX, 8'($urandom_range(lim_reply + 1, 255)), 1'b1);
            end else begin
                send_req(OP_UART_RX, 8'd0, 1'b1);
            end
        end
        for (k = $urandom_range(3); k > 0; k--) begin
            maybe_noise(1'b1);
            do b = 8'($urandom); while (b == CH_NL);
            send_req(OP_UART_RX, b, 1'b1);
        end
        send_req(OP_UART_RX, CH_NL, 1'b1);
    endtask

    task automatic run_random(input int target);
        phase_items = 0;
        while (phase_items < target) begin
            if ($urandom_range(99) < 20) send_broken();
            else send_cmd(pick_count(1, lim_send), pick_count(0, lim_reply));
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: prompt, ignored events, error mode, limits at reset values
        send_req(OP_START, 8'h00, 1'b0);
        send_req(OP_START, 8'hFF, 1'b0);
        send_req(OP_SPI_DONE, 8'h55, 1'b0);
        send_req(OP_UNUSED, 8'hAA, 1'b0);
        send_req(OP_UART_RX, CH_NL, 1'b0);
        send_req(OP_UART_RX, 8'hFF, 1'b0);
        send_req(OP_UART_RX, CH_NL, 1'b0);
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_UART_RX, 8'd0, 1'b0);
        send_req(OP_UART_RX, CH_NL, 1'b0);
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_UART_RX, 8'(MAX_SEND_RST + 8'd1), 1'b0);
        send_req(OP_UART_RX, CH_NL, 1'b0);
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_UART_RX, MAX_SEND_RST, 1'b0);
        send_req(OP_UART_RX, 8'(MAX_REPLY_RST + 8'd1), 1'b0);
        send_req(OP_UART_RX, CH_NL, 1'b0);
        // zero reply count: chip select up and prompt on the last send
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_UART_RX, 8'd1, 1'b0);
        send_req(OP_UART_RX, 8'd0, 1'b0);
        send_req(OP_UART_RX, 8'hFF, 1'b0);
        send_req(OP_SPI_DONE, 8'h00, 1'b0);
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_UART_RX, 8'd1, 1'b0);
        send_req(OP_UART_RX, 8'd1, 1'b0);
        send_req(OP_UART_RX, 8'h00, 1'b0);
        send_req(OP_UART_RX, CH_EQUAL, 1'b0);
        send_req(OP_SPI_DONE, 8'hFF, 1'b0);
        send_req(OP_SPI_DONE, 8'hFF, 1'b0);
        wait_drained();

        // lowest limits; long result hold-off while requests keep coming
        write_limits(1, 0);
        run_random(25);
        hold_off_req = 1'b1;
        run_random(30);
        wait_drained();

        // highest limits, sender mostly idle
        tx_idle_pct  = 76;
        rx_stall_pct = 28;
        write_limits(255, 255);
        run_random(25);
        wait_drained();
        run_random(25);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_limits($urandom_range(2, 40), $urandom_range(1, 40));
        run_random(50);
        wait_drained();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> uart_to_spi_command_bridge.f
hw/rtl/ucb_pkg.sv
hw/rtl/ucb_ctrl.sv
hw/rtl/ucb_rfifo.sv
hw/rtl/uart_to_spi_command_bridge.sv
hw/rtl/ucb_checker.sv
verif/ucb_bridge_checker.sv
verif/tb_uart_to_spi_command_bridge.sv
